FILE: hdl/pcos_pkg.sv
// ----------------------------------------------------------------------------
// pcos_pkg
// Shared types, codes and helpers of the priority class order store.
// ----------------------------------------------------------------------------
package pcos_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int NUM_CLASSES  = 4;   // classes in use; class ports are 2 bits

  localparam int ID_W   = 32;
  localparam int DAYS_W = 16;
  localparam int CLS_W  = 2;
  localparam int SEQ_W  = 32;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;

  // commands
  localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MOVE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EXTRACT = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP     = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

  // one word of the entry memory
  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [DAYS_W-1:0] days;
    logic [CLS_W-1:0]  cls;
    logic [SEQ_W-1:0]  seq;
  } entry_t;

  // command context handed to the scan unit
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [CLS_W-1:0] cls;
    logic [ID_W-1:0]  id;
  } scan_ctx_t;

  // best match found by the scan unit
  typedef struct packed {
    logic              found;
    logic [ID_W-1:0]   id;
    logic [DAYS_W-1:0] days;
  } scan_res_t;

  // class number folded into range; input is below twice NUM_CLASSES
  function automatic logic [CLS_W-1:0] class_fold(input logic [CLS_W-1:0] c);
    logic [4:0] wide;
    begin
      wide = {3'b000, c};
      if (wide >= 5'(NUM_CLASSES)) begin
        class_fold = CLS_W'(wide - 5'(NUM_CLASSES));
      end else begin
        class_fold = c;
      end
    end
  endfunction

endpackage

FILE: hdl/pcos_mem.sv
// ----------------------------------------------------------------------------
// pcos_mem
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pcos_mem #(
  parameter int CAPACITY = pcos_pkg::CAPACITY_DEF,
  localparam int ADDR_W = $clog2(CAPACITY)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  pcos_pkg::entry_t  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output pcos_pkg::entry_t  rd_data
);

  pcos_pkg::entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/pcos_scan.sv
// ----------------------------------------------------------------------------
// pcos_scan
// Pipelined pass over the entry memory: qualifies each entry for the
// current command and keeps the best candidate and its slot.
// ----------------------------------------------------------------------------
module pcos_scan #(
  parameter int CAPACITY = pcos_pkg::CAPACITY_DEF,
  localparam int ADDR_W = $clog2(CAPACITY)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clear,
  input  pcos_pkg::scan_ctx_t        ctx,
  input  logic                       rd_en,
  input  logic [ADDR_W-1:0]          rd_addr,
  input  pcos_pkg::entry_t           rd_data,
  input  logic [pcos_pkg::SEQ_W-1:0] next_seq,
  output pcos_pkg::scan_res_t        res,
  output logic [ADDR_W-1:0]          slot
);

  // stage A: aligned with memory read data
  logic              q_valid;
  logic [ADDR_W-1:0] q_addr;

  // stage B: qualified entry with its age
  logic                        b_valid;
  logic [ADDR_W-1:0]           b_addr;
  logic [pcos_pkg::ID_W-1:0]   b_id;
  logic [pcos_pkg::DAYS_W-1:0] b_days;
  logic [pcos_pkg::SEQ_W-1:0]  b_age;

  logic [pcos_pkg::SEQ_W-1:0] best_age;
  logic                       cand;
  logic                       take;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else begin
      q_valid <= rd_en;
    end
    q_addr <= rd_addr;
  end

  always_comb begin
    case (ctx.cmd)
      pcos_pkg::CMD_INSERT:  cand = !rd_data.valid;
      pcos_pkg::CMD_MOVE:    cand = rd_data.valid && (rd_data.cls == ctx.cls) &&
                                    (rd_data.id == ctx.id);
      pcos_pkg::CMD_EXTRACT: cand = rd_data.valid && (rd_data.cls == ctx.cls);
      default:               cand = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= q_valid && cand;
    end
    b_addr <= q_addr;
    b_id   <= rd_data.id;
    b_days <= rd_data.days;
    b_age  <= next_seq - rd_data.seq;
  end

  // insert keeps the lowest free slot; move the oldest match;
  // extract the greatest days, ties to the oldest
  always_comb begin
    case (ctx.cmd)
      pcos_pkg::CMD_INSERT:  take = !res.found;
      pcos_pkg::CMD_MOVE:    take = !res.found || (b_age > best_age);
      pcos_pkg::CMD_EXTRACT: take = !res.found || (b_days > res.days) ||
                                    ((b_days == res.days) && (b_age > best_age));
      default:               take = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      res.found <= 1'b0;
    end else if (b_valid && take) begin
      res.found <= 1'b1;
    end
    if (!clear && b_valid && take) begin
      res.id   <= b_id;
      res.days <= b_days;
      best_age <= b_age;
      slot     <= b_addr;
    end
  end

endmodule

FILE: hdl/priority_class_order_store.sv
// ----------------------------------------------------------------------------
// priority_class_order_store
// Order store with per-class arrival order: insert, move, extract greatest days.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Every item yields
// exactly one result, shown on status, result_id and result_days for the
// single cycle in which done is high; the receiver cannot hold it off. An
// item occupies the block from acceptance to the done cycle, and the next
// item may be accepted in that done cycle. The busy span is set by the pass
// over the entry memory, one read per cycle through its single read port,
// plus the pipeline drain and the write-back state. After reset the block
// clears the memory with busy high before the first item is taken.
// ----------------------------------------------------------------------------
module priority_class_order_store #(
  parameter int CAPACITY = pcos_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [pcos_pkg::CMD_W-1:0]    command,
  input  logic [pcos_pkg::ID_W-1:0]     order_id,
  input  logic [pcos_pkg::DAYS_W-1:0]   order_days,
  input  logic [pcos_pkg::CLS_W-1:0]    from_class,
  input  logic [pcos_pkg::CLS_W-1:0]    to_class,
  output logic                          done,
  output logic [pcos_pkg::STAT_W-1:0]   status,
  output logic [pcos_pkg::ID_W-1:0]     result_id,
  output logic [pcos_pkg::DAYS_W-1:0]   result_days
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 2);

  // sequencer states
  localparam logic [1:0] S_CLEAR = 2'd0;  // memory clearing pass
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;  // reads plus pipeline drain
  localparam logic [1:0] S_WRITE = 2'd3;  // write-back and result

  logic [1:0]       state;
  logic [CNT_W-1:0] cnt;

  // latched item
  pcos_pkg::scan_ctx_t           ctx;
  logic [pcos_pkg::CLS_W-1:0]    to_cls;
  logic [pcos_pkg::DAYS_W-1:0]   days_r;

  // sequence stamp for list order
  logic [pcos_pkg::SEQ_W-1:0]    next_seq;

  // memory ports
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  pcos_pkg::entry_t  wr_data;
  logic              rd_en;
  pcos_pkg::entry_t  rd_data;

  pcos_pkg::scan_res_t res;
  logic [ADDR_W-1:0]   slot;
  logic                scan_clear;
  logic                stamp;

  assign busy       = (state != S_IDLE);
  assign scan_clear = (state == S_IDLE);
  assign rd_en      = (state == S_SCAN) && (cnt < CNT_W'(CAPACITY));

  // an insert that finds a free slot and a found move stamp an entry
  assign stamp = (state == S_WRITE) && res.found &&
                 ((ctx.cmd == pcos_pkg::CMD_INSERT) || (ctx.cmd == pcos_pkg::CMD_MOVE));

  pcos_mem #(
    .CAPACITY (CAPACITY)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (cnt[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  pcos_scan #(
    .CAPACITY (CAPACITY)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .clear    (scan_clear),
    .ctx      (ctx),
    .rd_en    (rd_en),
    .rd_addr  (cnt[ADDR_W-1:0]),
    .rd_data  (rd_data),
    .next_seq (next_seq),
    .res      (res),
    .slot     (slot)
  );

  // write port: clearing pass, or write-back of the chosen slot
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot;
    wr_data = '0;
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = cnt[ADDR_W-1:0];
    end else if (state == S_WRITE && res.found) begin
      case (ctx.cmd)
        pcos_pkg::CMD_INSERT: begin
          wr_en   = 1'b1;
          wr_data = '{valid: 1'b1, id: ctx.id, days: days_r, cls: to_cls, seq: next_seq};
        end
        pcos_pkg::CMD_MOVE: begin
          wr_en   = 1'b1;
          wr_data = '{valid: 1'b1, id: res.id, days: res.days, cls: to_cls, seq: next_seq};
        end
        pcos_pkg::CMD_EXTRACT: begin
          wr_en   = 1'b1;   // all-zero word frees the slot
        end
        default: begin
          wr_en   = 1'b0;
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      cnt      <= '0;
      next_seq <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          if (cnt == CNT_W'(CAPACITY - 1)) begin
            state <= S_IDLE;
          end
          cnt <= cnt + 1'b1;
        end
        S_IDLE: begin
          cnt <= '0;
          if (start) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(CAPACITY + 1)) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (stamp) begin
            next_seq <= next_seq + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // item capture; classes folded into range on the way in
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      ctx.cmd <= command;
      ctx.cls <= pcos_pkg::class_fold(from_class);
      ctx.id  <= order_id;
      to_cls  <= pcos_pkg::class_fold(to_class);
      days_r  <= order_days;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == S_WRITE) begin
      status      <= pcos_pkg::ST_OK;
      result_id   <= '0;
      result_days <= '0;
      case (ctx.cmd)
        pcos_pkg::CMD_INSERT: begin
          if (!res.found) begin
            status <= pcos_pkg::ST_FULL;
          end
        end
        pcos_pkg::CMD_MOVE: begin
          if (res.found) begin
            result_id <= res.id;
          end else begin
            status <= pcos_pkg::ST_NOT_FOUND;
          end
        end
        pcos_pkg::CMD_EXTRACT: begin
          if (res.found) begin
            result_id   <= res.id;
            result_days <= res.days;
          end else begin
            status <= pcos_pkg::ST_EMPTY;
          end
        end
        default: begin
          status <= pcos_pkg::ST_OK;
        end
      endcase
    end
  end

  // a result only follows the write-back cycle
  a_done_after_write: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_WRITE)
    else $error("done without write-back");

  // an accepted item starts a scan
  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_SCAN) && (cnt == '0))
    else $error("accepted item did not start a scan");

  // no memory writes while a scan reads
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !wr_en)
    else $error("memory write during scan");

  // each stamp advances the sequence by one
  a_seq_step: assert property (@(posedge clk) disable iff (rst)
    stamp |=> next_seq == $past(next_seq) + 1'b1)
    else $error("sequence not advanced on stamp");

  // the sequence only moves on a stamp
  a_seq_hold: assert property (@(posedge clk) disable iff (rst)
    (!stamp && state != S_CLEAR) |=> $stable(next_seq))
    else $error("sequence changed without stamp");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for priority_class_order_store: insert, move, extract.
// ----------------------------------------------------------------------------
// A table of directed items runs first, then about 1400 random items in
// traffic episodes that fill, drain or churn the store. An internal order
// store mirrors the block and predicts each result when its item is taken.
// Results are matched in order against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam int RANDOM_ITEMS = 1400;
  localparam int HOT_IDS      = 16;

  // one command item as seen on the input ports
  typedef struct packed {
    logic [pcos_pkg::CMD_W-1:0]  cmd;
    logic [pcos_pkg::ID_W-1:0]   id;
    logic [pcos_pkg::DAYS_W-1:0] days;
    logic [pcos_pkg::CLS_W-1:0]  from_cls;
    logic [pcos_pkg::CLS_W-1:0]  to_cls;
  } order_cmd_t;

  // one result as seen on the output ports
  typedef struct packed {
    logic [pcos_pkg::STAT_W-1:0] status;
    logic [pcos_pkg::ID_W-1:0]   id;
    logic [pcos_pkg::DAYS_W-1:0] days;
  } order_result_t;

  // directed row: when pinned, the typed result stands in for the prediction
  typedef struct packed {
    order_cmd_t    item;
    logic          pinned;
    order_result_t want;
  } directed_row_t;

  typedef enum {FILL_UP, DRAIN_DOWN, CHURN} traffic_mode_t;

  // --------------------------------------------------------------------------
  // clock, reset and DUT ports; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                          clk         = 1'b0;
  logic                          rst         = 1'b1;
  logic                          start       = 1'b0;
  logic [pcos_pkg::CMD_W-1:0]    command     = pcos_pkg::CMD_NOP;
  logic [pcos_pkg::ID_W-1:0]     order_id    = '0;
  logic [pcos_pkg::DAYS_W-1:0]   order_days  = '0;
  logic [pcos_pkg::CLS_W-1:0]    from_class  = '0;
  logic [pcos_pkg::CLS_W-1:0]    to_class    = '0;
  logic                          busy;
  logic                          done;
  logic [pcos_pkg::STAT_W-1:0]   status;
  logic [pcos_pkg::ID_W-1:0]     result_id;
  logic [pcos_pkg::DAYS_W-1:0]   result_days;

  // sideband that travels with each driven item: a typed result, if any
  logic                pin_valid  = 1'b0;
  order_result_t       pin_result = '0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  priority_class_order_store u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .order_id    (order_id),
    .order_days  (order_days),
    .from_class  (from_class),
    .to_class    (to_class),
    .done        (done),
    .status      (status),
    .result_id   (result_id),
    .result_days (result_days)
  );

  // --------------------------------------------------------------------------
  // mirror of the order store
  // --------------------------------------------------------------------------
  logic                        shadow_valid [pcos_pkg::CAPACITY_DEF];
  logic [pcos_pkg::ID_W-1:0]   shadow_id    [pcos_pkg::CAPACITY_DEF];
  logic [pcos_pkg::DAYS_W-1:0] shadow_days  [pcos_pkg::CAPACITY_DEF];
  logic [pcos_pkg::CLS_W-1:0]  shadow_cls   [pcos_pkg::CAPACITY_DEF];
  logic [pcos_pkg::SEQ_W-1:0]  shadow_seq   [pcos_pkg::CAPACITY_DEF];
  logic [pcos_pkg::SEQ_W-1:0]  shadow_next_seq;

  initial begin
    foreach (shadow_valid[k]) shadow_valid[k] = 1'b0;
    shadow_next_seq = '0;
  end

  // distance back from the newest stamp: larger means earlier in the list
  function automatic logic [pcos_pkg::SEQ_W-1:0] list_age(input int slot);
    list_age = shadow_next_seq - shadow_seq[slot];
  endfunction

  // each successful insert and move stamps the entry and advances the sequence
  task automatic stamp_slot(input int slot, input logic [pcos_pkg::CLS_W-1:0] cls);
    shadow_cls[slot] = cls;
    shadow_seq[slot] = shadow_next_seq;
    shadow_next_seq  = shadow_next_seq + 1'b1;
  endtask

  // predicts one result and updates the mirror
  task automatic apply_order_cmd(input order_cmd_t c, output order_result_t r);
    logic [pcos_pkg::CLS_W-1:0] src_cls;
    logic [pcos_pkg::CLS_W-1:0] dst_cls;
    logic                       hit;
    int                         pick;
    r       = '0;
    r.status = pcos_pkg::ST_OK;
    hit     = 1'b0;
    pick    = 0;
    src_cls = pcos_pkg::CLS_W'(int'(c.from_cls) % pcos_pkg::NUM_CLASSES);
    dst_cls = pcos_pkg::CLS_W'(int'(c.to_cls) % pcos_pkg::NUM_CLASSES);
    case (c.cmd)
      pcos_pkg::CMD_INSERT: begin
        // lowest free slot
        for (int i = 0; i < pcos_pkg::CAPACITY_DEF; i++) begin
          if (!hit && !shadow_valid[i]) begin
            hit  = 1'b1;
            pick = i;
          end
        end
        if (!hit) begin
          r.status = pcos_pkg::ST_FULL;
        end else begin
          shadow_valid[pick] = 1'b1;
          shadow_id[pick]    = c.id;
          shadow_days[pick]  = c.days;
          stamp_slot(pick, dst_cls);
        end
      end
      pcos_pkg::CMD_MOVE: begin
        // duplicate ids: earliest match in the class wins
        for (int i = 0; i < pcos_pkg::CAPACITY_DEF; i++) begin
          if (shadow_valid[i] && shadow_cls[i] == src_cls && shadow_id[i] == c.id) begin
            if (!hit || list_age(i) > list_age(pick)) begin
              hit  = 1'b1;
              pick = i;
            end
          end
        end
        if (!hit) begin
          r.status = pcos_pkg::ST_NOT_FOUND;
        end else begin
          stamp_slot(pick, dst_cls);
          r.id = shadow_id[pick];
        end
      end
      pcos_pkg::CMD_EXTRACT: begin
        // greatest days; on a tie the earliest in list order
        for (int i = 0; i < pcos_pkg::CAPACITY_DEF; i++) begin
          if (shadow_valid[i] && shadow_cls[i] == src_cls) begin
            if (!hit || shadow_days[i] > shadow_days[pick] ||
                (shadow_days[i] == shadow_days[pick] && list_age(i) > list_age(pick))) begin
              hit  = 1'b1;
              pick = i;
            end
          end
        end
        if (!hit) begin
          r.status = pcos_pkg::ST_EMPTY;
        end else begin
          shadow_valid[pick] = 1'b0;
          r.id   = shadow_id[pick];
          r.days = shadow_days[pick];
        end
      end
      default: begin
        // unused command: nothing changes, ok with zeros
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // result checking
  // --------------------------------------------------------------------------
  order_result_t pending_results [$];
  int            mismatch_count = 0;

  task automatic report_mismatch(input string what, input order_result_t want,
                                 input order_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t ns %s: want status %0d id %h days %h, got status %0d id %h days %h",
               $time, what, want.status, want.id, want.days, got.status, got.id, got.days);
    end
  endtask

  // A result is due at the edge that ends its done cycle. The next item may
  // be taken on that same edge, so the result is retired before the new
  // item's prediction is queued. Port values read here are pre-edge values.
  always @(posedge clk) begin
    order_result_t got;
    order_result_t want;
    order_result_t predicted;
    if (!rst) begin
      if (done !== 1'b0) begin
        got = {status, result_id, result_days};
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (done !== 1'b1 || got.status !== want.status || got.id !== want.id ||
              got.days !== want.days) begin
            report_mismatch("result mismatch", want, got);
          end
        end
      end
      if (start && busy === 1'b0) begin
        apply_order_cmd({command, order_id, order_days, from_class, to_class}, predicted);
        pending_results.push_back(pin_valid ? pin_result : predicted);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  localparam int N_DIRECTED = 23;

  // rows: item {cmd, id, days, from, to}, pinned, typed result {status, id, days}
  directed_row_t directed_rows [N_DIRECTED] = '{
    // empty store: every lookup fails, unused command is a quiet ok
    '{'{pcos_pkg::CMD_EXTRACT, 32'h0, 16'h0, 2'd0, 2'd0}, 1'b1,
      '{pcos_pkg::ST_EMPTY, 32'h0, 16'h0}},
    '{'{pcos_pkg::CMD_MOVE, 32'h5, 16'h0, 2'd1, 2'd2}, 1'b1,
      '{pcos_pkg::ST_NOT_FOUND, 32'h0, 16'h0}},
    '{'{pcos_pkg::CMD_NOP, 32'hFFFFFFFF, 16'hFFFF, 2'd3, 2'd3}, 1'b1,
      '{pcos_pkg::ST_OK, 32'h0, 16'h0}},
    // field extremes in class 3, with a days tie broken by arrival
    '{'{pcos_pkg::CMD_INSERT, 32'hFFFFFFFF, 16'hFFFF, 2'd0, 2'd3}, 1'b1,
      '{pcos_pkg::ST_OK, 32'h0, 16'h0}},
    '{'{pcos_pkg::CMD_INSERT, 32'h0, 16'h0, 2'd0, 2'd3}, 1'b1,
      '{pcos_pkg::ST_OK, 32'h0, 16'h0}},
    '{'{pcos_pkg::CMD_INSERT, 32'h12345678, 16'hFFFF, 2'd0, 2'd3}, 1'b1,
      '{pcos_pkg::ST_OK, 32'h0, 16'h0}},
    '{'{pcos_pkg::CMD_EXTRACT, 32'h0, 16'h0, 2'd3, 2'd0}, 1'b1,
      '{pcos_pkg::ST_OK, 32'hFFFFFFFF, 16'hFFFF}},
    '{'{pcos_pkg::CMD_EXTRACT, 32'h0, 16'h0, 2'd3, 2'd0}, 1'b1,
      '{pcos_pkg::ST_OK, 32'h12345678, 16'hFFFF}},
    '{'{pcos_pkg::CMD_EXTRACT, 32'h0, 16'h0, 2'd3, 2'd0}, 1'b1,
      '{pcos_pkg::ST_OK, 32'h0, 16'h0}},
    '{'{pcos_pkg::CMD_EXTRACT, 32'h0, 16'h0, 2'd3, 2'd0}, 1'b1,
      '{pcos_pkg::ST_EMPTY, 32'h0, 16'h0}},
    // duplicate ids, move within one class, move between classes
    '{'{pcos_pkg::CMD_INSERT,  32'h7, 16'd100,  2'd0, 2'd0}, 1'b0, '0},
    '{'{pcos_pkg::CMD_INSERT,  32'h7, 16'd200,  2'd0, 2'd0}, 1'b0, '0},
    '{'{pcos_pkg::CMD_INSERT,  32'h9, 16'd50,   2'd0, 2'd1}, 1'b0, '0},
    '{'{pcos_pkg::CMD_MOVE,    32'h7, 16'h0,    2'd0, 2'd0}, 1'b0, '0},
    '{'{pcos_pkg::CMD_MOVE,    32'h7, 16'h0,    2'd0, 2'd2}, 1'b0, '0},
    '{'{pcos_pkg::CMD_MOVE, 32'h9, 16'h0, 2'd0, 2'd2}, 1'b1,
      '{pcos_pkg::ST_NOT_FOUND, 32'h0, 16'h0}},
    '{'{pcos_pkg::CMD_MOVE,    32'h9, 16'hFFFF, 2'd1, 2'd1}, 1'b0, '0},
    '{'{pcos_pkg::CMD_EXTRACT, 32'h0, 16'h0,    2'd2, 2'd0}, 1'b0, '0},
    '{'{pcos_pkg::CMD_EXTRACT, 32'h0, 16'h0,    2'd0, 2'd0}, 1'b0, '0},
    '{'{pcos_pkg::CMD_EXTRACT, 32'h0, 16'h0,    2'd1, 2'd0}, 1'b0, '0},
    '{'{pcos_pkg::CMD_EXTRACT, 32'h0, 16'h0, 2'd0, 2'd0}, 1'b1,
      '{pcos_pkg::ST_EMPTY, 32'h0, 16'h0}},
    // alternating bit patterns
    '{'{pcos_pkg::CMD_INSERT, 32'hA5A5A5A5, 16'h5A5A, 2'd2, 2'd1}, 1'b0, '0},
    '{'{pcos_pkg::CMD_INSERT, 32'h5A5A5A5A, 16'hA5A5, 2'd1, 2'd1}, 1'b0, '0}
  };

  // small pool of ids so that moves find their targets and duplicates occur
  logic [pcos_pkg::ID_W-1:0] hot_ids [HOT_IDS];
  int                        burst_left = 0;

  initial begin
    foreach (hot_ids[k]) hot_ids[k] = $urandom;
  end

  function automatic order_cmd_t random_order(input traffic_mode_t mode);
    order_cmd_t c;
    int         roll;
    int         pct_insert;
    int         pct_move;
    if ($urandom_range(0, 19) == 0) hot_ids[$urandom_range(0, HOT_IDS - 1)] = $urandom;
    case (mode)
      FILL_UP:    begin pct_insert = 75; pct_move = 15; end
      DRAIN_DOWN: begin pct_insert = 20; pct_move = 15; end
      default:    begin pct_insert = 40; pct_move = 25; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      c.cmd = pcos_pkg::CMD_NOP;
    end else if (roll < pct_insert) begin
      c.cmd = pcos_pkg::CMD_INSERT;
    end else if (roll < pct_insert + pct_move) begin
      c.cmd = pcos_pkg::CMD_MOVE;
    end else begin
      c.cmd = pcos_pkg::CMD_EXTRACT;
    end
    c.id = ($urandom_range(0, 3) == 0) ? pcos_pkg::ID_W'($urandom)
                                        : hot_ids[$urandom_range(0, HOT_IDS - 1)];
    // tight days range makes ties common
    case ($urandom_range(0, 9))
      0:       c.days = '0;
      1:       c.days = '1;
      2, 3, 4: c.days = pcos_pkg::DAYS_W'($urandom_range(0, 3));
      default: c.days = pcos_pkg::DAYS_W'($urandom);
    endcase
    c.from_cls = pcos_pkg::CLS_W'($urandom_range(0, 3));
    c.to_cls   = pcos_pkg::CLS_W'($urandom_range(0, 3));
    return c;
  endfunction

  // Holds start high until the item is taken. Returns at the taking edge.
  task automatic drive_order(input order_cmd_t c, input logic pinned,
                             input order_result_t want);
    start      <= 1'b1;
    command    <= c.cmd;
    order_id   <= c.id;
    order_days <= c.days;
    from_class <= c.from_cls;
    to_class   <= c.to_cls;
    pin_valid  <= pinned;
    pin_result <= want;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Bursts of back-to-back items with random gaps; fields carry noise while
  // start is low. The gaps land on any phase of the busy window.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 90);
      if (gap > 0) begin
        start      <= 1'b0;
        command    <= pcos_pkg::CMD_W'($urandom);
        order_id   <= $urandom;
        order_days <= pcos_pkg::DAYS_W'($urandom);
        from_class <= pcos_pkg::CLS_W'($urandom);
        to_class   <= pcos_pkg::CLS_W'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    traffic_mode_t mode;
    int            episode_left;
    mode         = CHURN;
    episode_left = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      drive_order(directed_rows[k].item, directed_rows[k].pinned, directed_rows[k].want);
      pace_sender();
    end

    // episodes long enough to run the store into full and back to empty
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (episode_left == 0) begin
        mode         = traffic_mode_t'($urandom_range(0, 2));
        episode_left = $urandom_range(60, 200);
      end
      episode_left--;
      drive_order(random_order(mode), 1'b0, '0);
      pace_sender();
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // stray results after the last one would show up within one busy window
    repeat (pcos_pkg::CAPACITY_DEF + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // worst case is about 1430 items, each with a full busy window and a
  // maximal gap, roughly 2 ms; allow five times that
  initial begin
    #(10_000_000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/pcos_pkg.sv
hdl/pcos_mem.sv
hdl/pcos_scan.sv
hdl/priority_class_order_store.sv
verif/tb.sv
